// ----- src/hsv_to_rgb_converter_assert.svh -----
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion forms used by the converter's top level.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// The condition must never hold outside reset.
`define HSVRGB_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define HSVRGB_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Constants, field widths and the queued item type shared by all modules.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   localparam int FRAC_BITS_DEFAULT   = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int HUE_W  = 16;
   localparam int SAT_W  = 9;
   localparam int VAL_W  = 9;
   localparam int CHAN_W = 8;
   localparam int SEC_W  = 3;
   // Offsets within a sector reach 3840, which needs 12 bits.
   localparam int OFS_W  = 12;

   localparam logic [HUE_W-1:0] FULL_CIRCLE  = 16'd23040;
   localparam logic [OFS_W-1:0] SECTOR_UNITS = 12'd3840;
   localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;
   // 255 / 15 where 3840 = 15 * 256.
   localparam int CHAN_SCALE = 17;

   localparam logic [SEC_W-1:0] SEC_RED_YEL  = 3'd0;
   localparam logic [SEC_W-1:0] SEC_YEL_GRN  = 3'd1;
   localparam logic [SEC_W-1:0] SEC_GRN_CYN  = 3'd2;
   localparam logic [SEC_W-1:0] SEC_CYN_BLU  = 3'd3;
   localparam logic [SEC_W-1:0] SEC_BLU_MAG  = 3'd4;
   localparam logic [SEC_W-1:0] SEC_MAG_RED  = 3'd5;

   // One classified color: each channel is v * (1 - s * ofs / 3840).
   typedef struct packed {
      logic [SAT_W-1:0] sat;
      logic [VAL_W-1:0] val;
      logic [OFS_W-1:0] ofs_red;
      logic [OFS_W-1:0] ofs_green;
      logic [OFS_W-1:0] ofs_blue;
   } hsvrgb_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } hsvrgb_qstat_type;

endpackage

// ----- src/hsvrgb_front.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter front end
// Accepts an item, saturates saturation and value, wraps an out-of-range hue to
// zero, resolves the hue sector into per-channel offsets and queues the result.
// ----------------------------------------------------------------------------
module hsvrgb_front #(
   parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hsvrgb_pkg::HUE_W-1:0]   req_hue_q,
   input  logic [hsvrgb_pkg::SAT_W-1:0]   req_sat_q,
   input  logic [hsvrgb_pkg::VAL_W-1:0]   req_val_q,
   input  hsvrgb_pkg::hsvrgb_qstat_type   q_stat,
   output logic                           q_push,
   output hsvrgb_pkg::hsvrgb_item_type    q_item
);
   import hsvrgb_pkg::*;

   localparam int CmpW = (FRAC_BITS + 1 > SAT_W) ? FRAC_BITS + 1 : SAT_W;

   logic                      front_valid_ff, front_valid_in;
   hsvrgb_item_type           front_item_ff, front_item_in;
   logic [CmpW-1:0]           one_w;
   logic [HUE_W-1:0]          hue;
   logic [SEC_W-1:0]          sector;
   logic [HUE_W-1:0]          base;
   logic [OFS_W-1:0]          ofs_rem, ofs_inv;

   assign one_w = CmpW'(1) << FRAC_BITS;
   assign hue   = (req_hue_q >= FULL_CIRCLE) ? '0 : req_hue_q;

   always_comb begin
      if (hue >= HUE_W'(5 * SECTOR_UNITS)) begin
         sector = SEC_MAG_RED;
      end else if (hue >= HUE_W'(4 * SECTOR_UNITS)) begin
         sector = SEC_BLU_MAG;
      end else if (hue >= HUE_W'(3 * SECTOR_UNITS)) begin
         sector = SEC_CYN_BLU;
      end else if (hue >= HUE_W'(2 * SECTOR_UNITS)) begin
         sector = SEC_GRN_CYN;
      end else if (hue >= HUE_W'(SECTOR_UNITS)) begin
         sector = SEC_YEL_GRN;
      end else begin
         sector = SEC_RED_YEL;
      end
   end

   assign base    = HUE_W'(sector) * HUE_W'(SECTOR_UNITS);
   assign ofs_rem = OFS_W'(hue - base);
   assign ofs_inv = SECTOR_UNITS - ofs_rem;

   always_comb begin
      front_item_in.sat = (CmpW'(req_sat_q) > one_w) ? one_w[SAT_W-1:0] : req_sat_q;
      front_item_in.val = (CmpW'(req_val_q) > one_w) ? one_w[VAL_W-1:0] : req_val_q;
      case (sector)
         SEC_RED_YEL: begin
            front_item_in.ofs_red   = '0;
            front_item_in.ofs_green = ofs_inv;
            front_item_in.ofs_blue  = SECTOR_UNITS;
         end
         SEC_YEL_GRN: begin
            front_item_in.ofs_red   = ofs_rem;
            front_item_in.ofs_green = '0;
            front_item_in.ofs_blue  = SECTOR_UNITS;
         end
         SEC_GRN_CYN: begin
            front_item_in.ofs_red   = SECTOR_UNITS;
            front_item_in.ofs_green = '0;
            front_item_in.ofs_blue  = ofs_inv;
         end
         SEC_CYN_BLU: begin
            front_item_in.ofs_red   = SECTOR_UNITS;
            front_item_in.ofs_green = ofs_rem;
            front_item_in.ofs_blue  = '0;
         end
         SEC_BLU_MAG: begin
            front_item_in.ofs_red   = ofs_inv;
            front_item_in.ofs_green = SECTOR_UNITS;
            front_item_in.ofs_blue  = '0;
         end
         default: begin
            front_item_in.ofs_red   = '0;
            front_item_in.ofs_green = SECTOR_UNITS;
            front_item_in.ofs_blue  = ofs_rem;
         end
      endcase
   end

   assign req_stall      = front_valid_ff && q_stat.full;
   assign q_push         = front_valid_ff && !q_stat.full;
   assign q_item         = front_item_ff;
   assign front_valid_in = req_stall ? front_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         front_item_ff <= front_item_in;
      end
   end

endmodule

// ----- src/hsvrgb_queue.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter queue
// A short first-in first-out buffer of classified items between the front
// end and the arithmetic back end.
// ----------------------------------------------------------------------------
module hsvrgb_queue #(
   parameter int QUEUE_DEPTH = hsvrgb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_push,
   input  hsvrgb_pkg::hsvrgb_item_type    q_item_wr,
   input  logic                           q_pop,
   output hsvrgb_pkg::hsvrgb_item_type    q_item_rd,
   output hsvrgb_pkg::hsvrgb_qstat_type   q_stat
);
   import hsvrgb_pkg::*;

   localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   hsvrgb_item_type           slot_ff [QUEUE_DEPTH];
   logic [IdxW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]           count_ff, count_in;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == CntW'(QUEUE_DEPTH));
   assign q_item_rd    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= q_item_wr;
      end
   end

endmodule

// ----- src/hsvrgb_back.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter back end
// Three-stage arithmetic pipeline that turns a classified item into the
// three 8-bit channels and holds them in the output register.
// ----------------------------------------------------------------------------
module hsvrgb_back #(
   parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hsvrgb_pkg::hsvrgb_item_type    q_item,
   input  hsvrgb_pkg::hsvrgb_qstat_type   q_stat,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hsvrgb_pkg::CHAN_W-1:0]  rsp_red_out,
   output logic [hsvrgb_pkg::CHAN_W-1:0]  rsp_green_out,
   output logic [hsvrgb_pkg::CHAN_W-1:0]  rsp_blue_out
);
   import hsvrgb_pkg::*;

   localparam int NumChan = 3;
   localparam int TermW   = FRAC_BITS + OFS_W;
   localparam int ProdW   = SAT_W + OFS_W;
   localparam int MixW    = (TermW > ProdW) ? TermW : ProdW;
   localparam int FullW   = TermW + VAL_W;
   localparam int ScaleW  = FullW + 5;
   localparam int Shift   = 2 * FRAC_BITS + 8;

   logic                      advance;
   logic [OFS_W-1:0]          ofs [NumChan];
   logic [MixW-1:0]           whole;

   logic                      s1_valid_ff;
   logic [VAL_W-1:0]          s1_val_ff;
   logic [TermW-1:0]          s1_term_ff [NumChan];
   logic [TermW-1:0]          s1_term_in [NumChan];

   logic                      s2_valid_ff;
   logic [FullW-1:0]          s2_prod_ff [NumChan];
   logic [FullW-1:0]          s2_prod_in [NumChan];

   logic                      out_valid_ff;
   logic [CHAN_W-1:0]         out_chan_ff [NumChan];
   logic [CHAN_W-1:0]         out_chan_in [NumChan];

   assign advance = !(out_valid_ff && rsp_stall);
   assign q_pop   = advance && !q_stat.empty;

   assign ofs[0] = q_item.ofs_red;
   assign ofs[1] = q_item.ofs_green;
   assign ofs[2] = q_item.ofs_blue;
   assign whole  = MixW'(SECTOR_UNITS) << FRAC_BITS;

   always_comb begin
      for (int c = 0; c < NumChan; c++) begin
         s1_term_in[c] = TermW'(whole - MixW'(q_item.sat) * MixW'(ofs[c]));
         s2_prod_in[c] = FullW'(s1_val_ff) * FullW'(s1_term_ff[c]);
      end
   end

   always_comb begin
      logic [ScaleW-1:0] scaled;
      logic [ScaleW-1:0] level;
      for (int c = 0; c < NumChan; c++) begin
         scaled = ScaleW'(s2_prod_ff[c]) * ScaleW'(CHAN_SCALE);
         level  = scaled >> Shift;
         out_chan_in[c] = (level > ScaleW'(CHAN_MAX)) ? CHAN_MAX : level[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !q_stat.empty;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_val_ff <= q_item.val;
         for (int c = 0; c < NumChan; c++) begin
            s1_term_ff[c]  <= s1_term_in[c];
            s2_prod_ff[c]  <= s2_prod_in[c];
            out_chan_ff[c] <= out_chan_in[c];
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = out_chan_ff[0];
   assign rsp_green_out = out_chan_ff[1];
   assign rsp_blue_out  = out_chan_ff[2];

endmodule

// ----- src/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts one HSV color per item into 8-bit RGB by the six-sector method.
// ----------------------------------------------------------------------------
// The converter takes one item per clock while req_stall is low and returns one
// result per item, in order. A result passes through the front-end register,
// the queue and the back-end multiplier stages before it reaches the output
// register. The throughput is set by the back-end pipeline, which starts a new
// item every cycle and holds only while a result waits on rsp_stall; the queue
// lets the input side keep taking items during short stalls of the output
// side. Hue is in 1/64 degree, saturation and value are fixed point with
// FRAC_BITS fraction bits, and no reset-time clearing pass is needed.
module hsv_to_rgb_converter #(
   parameter int FRAC_BITS   = hsvrgb_pkg::FRAC_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = hsvrgb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hsvrgb_pkg::HUE_W-1:0]   req_hue_q,
   input  logic [hsvrgb_pkg::SAT_W-1:0]   req_sat_q,
   input  logic [hsvrgb_pkg::VAL_W-1:0]   req_val_q,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hsvrgb_pkg::CHAN_W-1:0]  rsp_red_out,
   output logic [hsvrgb_pkg::CHAN_W-1:0]  rsp_green_out,
   output logic [hsvrgb_pkg::CHAN_W-1:0]  rsp_blue_out
);
   import hsvrgb_pkg::*;

`include "hsv_to_rgb_converter_assert.svh"

   logic                q_push;
   logic                q_pop;
   hsvrgb_item_type     q_item_wr;
   hsvrgb_item_type     q_item_rd;
   hsvrgb_qstat_type    q_stat;

   hsvrgb_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_hue_q (req_hue_q),
      .req_sat_q (req_sat_q),
      .req_val_q (req_val_q),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_item    (q_item_wr)
   );

   hsvrgb_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_push    (q_push),
      .q_item_wr (q_item_wr),
      .q_pop     (q_pop),
      .q_item_rd (q_item_rd),
      .q_stat    (q_stat)
   );

   hsvrgb_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_item        (q_item_rd),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

   `HSVRGB_ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && q_stat.empty)
   `HSVRGB_ASSERT_NEVER(a_push_full, clock, reset, q_push && q_stat.full)
   `HSVRGB_ASSERT_NEXT(a_reset_empty, clock, reset, q_stat.empty && !rsp_valid && !req_stall)
   `HSVRGB_ASSERT_NEVER(a_stall_no_front, clock, reset, req_stall && !q_stat.full)

endmodule

// ----- tb/tb_hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed and random HSV colors through the converter while both sides
// idle at random in the first two phases, predicts each RGB result in fixed
// point, and compares every result in order against the prediction.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;
   import hsvrgb_pkg::*;

   localparam int FRAC_BITS = FRAC_BITS_DEFAULT;
   localparam int NUM_ITEMS = 1950;
   localparam int PHASE_ITEMS = 650;

   class rgb_scoreboard;
      typedef struct packed {
         logic [CHAN_W-1:0] red;
         logic [CHAN_W-1:0] green;
         logic [CHAN_W-1:0] blue;
      } rgb_type;

      rgb_type pending_rgb[$];
      int failures = 0;

      function logic [CHAN_W-1:0] scale_channel(longint unsigned num,
                                                longint unsigned den);
         longint unsigned q;
         q = (longint'(CHAN_MAX) * num) / den;
         if (q > CHAN_MAX) begin
            q = CHAN_MAX;
         end
         return q[CHAN_W-1:0];
      endfunction

      function rgb_type convert_hsv(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                    logic [VAL_W-1:0] val);
         longint unsigned one, h, s, v, ofs, span, den, nv, n1, n2, n3, pr, pg, pb;
         logic [SEC_W-1:0] sector;
         rgb_type rgb;
         one = longint'(1) << FRAC_BITS;
         span = SECTOR_UNITS;
         h = hue;
         s = sat;
         v = val;
         // A hue of a full circle or more wraps to the start of the red sector.
         if (h >= FULL_CIRCLE) begin
            h = 0;
         end
         if (s > one) begin
            s = one;
         end
         if (v > one) begin
            v = one;
         end
         sector = SEC_W'(h / span);
         ofs = h % span;
         den = one * one * span;
         nv = v * one * span;
         n1 = v * (one - s) * span;
         n2 = v * (one * span - s * ofs);
         n3 = v * (one * span - s * (span - ofs));
         if (s == 0) begin
            pr = nv;
            pg = nv;
            pb = nv;
         end else begin
            case (sector)
               SEC_RED_YEL: begin pr = nv; pg = n3; pb = n1; end
               SEC_YEL_GRN: begin pr = n2; pg = nv; pb = n1; end
               SEC_GRN_CYN: begin pr = n1; pg = nv; pb = n3; end
               SEC_CYN_BLU: begin pr = n1; pg = n2; pb = nv; end
               SEC_BLU_MAG: begin pr = n3; pg = n1; pb = nv; end
               default:     begin pr = nv; pg = n1; pb = n2; end
            endcase
         end
         rgb.red = scale_channel(pr, den);
         rgb.green = scale_channel(pg, den);
         rgb.blue = scale_channel(pb, den);
         return rgb;
      endfunction

      function void note_hsv(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                             logic [VAL_W-1:0] val);
         pending_rgb.push_back(convert_hsv(hue, sat, val));
      endfunction

      function void check_rgb(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                              logic [CHAN_W-1:0] blue);
         rgb_type want;
         if (pending_rgb.size() == 0) begin
            $display("%0t: unexpected item expected none actual %0d %0d %0d",
                     $time, red, green, blue);
            failures++;
            return;
         end
         want = pending_rgb.pop_front();
         if (red !== want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, red);
            failures++;
         end
         if (green !== want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, green);
            failures++;
         end
         if (blue !== want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, blue);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [HUE_W-1:0] req_hue_q = '0;
   logic [SAT_W-1:0] req_sat_q = '0;
   logic [VAL_W-1:0] req_val_q = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CHAN_W-1:0] rsp_red_out;
   logic [CHAN_W-1:0] rsp_green_out;
   logic [CHAN_W-1:0] rsp_blue_out;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   rgb_scoreboard sb;

   hsv_to_rgb_converter #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_hue_q(req_hue_q),
      .req_sat_q(req_sat_q),
      .req_val_q(req_val_q),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_rgb(rsp_red_out, rsp_green_out, rsp_blue_out);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_hsv(input logic [HUE_W-1:0] hue, input logic [SAT_W-1:0] sat,
                           input logic [VAL_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_hue_q <= hue;
      req_sat_q <= sat;
      req_val_q <= val;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_hsv(hue, sat, val);
      @(negedge clock);
   endtask

   initial begin
      int unsigned directed_hue [23] = '{0, 3839, 3840, 7680, 11520, 15360, 19200,
         23039, 23040, 65535, 23041, 1920, 5000, 9000, 12000, 13000, 17000, 20000,
         100, 0, 65535, 32768, 21845};
      int unsigned directed_sat [23] = '{256, 256, 256, 256, 256, 256, 256,
         256, 256, 511, 128, 0, 0, 0, 256, 511, 1, 255, 300, 0, 0, 257, 170};
      int unsigned directed_val [23] = '{256, 256, 256, 256, 256, 256, 256,
         256, 256, 511, 200, 256, 511, 0, 0, 511, 1, 255, 400, 0, 0, 257, 85};
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] sat;
      logic [VAL_W-1:0] val;
      int pick;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_ITEMS; i++) begin
         if (i == 0) begin
            send_idle_pct = 18;
            recv_idle_pct = 62;
         end else if (i == PHASE_ITEMS) begin
            send_idle_pct = 62;
            recv_idle_pct = 18;
         end else if (i == 2 * PHASE_ITEMS) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (i < $size(directed_hue)) begin
            hue = HUE_W'(directed_hue[i]);
            sat = SAT_W'(directed_sat[i]);
            val = VAL_W'(directed_val[i]);
         end else begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               hue = HUE_W'($urandom);
            end else if (pick < 18) begin
               hue = HUE_W'($urandom_range(6) * SECTOR_UNITS);
            end else begin
               hue = HUE_W'($urandom_range(FULL_CIRCLE));
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
               sat = '0;
            end else if (pick < 25) begin
               sat = SAT_W'(256);
            end else if (pick < 40) begin
               sat = SAT_W'($urandom_range(511));
            end else begin
               sat = SAT_W'($urandom_range(255));
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
               val = '0;
            end else if (pick < 20) begin
               val = VAL_W'(256);
            end else if (pick < 35) begin
               val = VAL_W'($urandom_range(511));
            end else begin
               val = VAL_W'($urandom_range(256));
            end
         end
         send_hsv(hue, sat, val);
      end
      req_valid <= 1'b0;
      while (sb.pending_rgb.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending_rgb.size() == 0) begin
         $display("tb_hsv_to_rgb_converter OK");
      end else begin
         $display("tb_hsv_to_rgb_converter NOT OK");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("tb_hsv_to_rgb_converter NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/hsvrgb_pkg.sv
src/hsvrgb_front.sv
src/hsvrgb_queue.sv
src/hsvrgb_back.sv
src/hsv_to_rgb_converter.sv
tb/tb_hsv_to_rgb_converter.sv
